// File: sv/assert_macros.svh
// Assertion macros used by the hasher controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/s256h_pkg.sv
// Types, constants, initial hash values and round constants for the SHA-256 stream hasher.
package s256h_pkg;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [5:0] LAST_FILL  = 6'd63;

    typedef struct packed {
        logic       load_byte;
        logic       pad_mark;
        logic       pad_fill;
        logic       pad_len;
        logic       start_round;
        logic       round_step;
        logic [5:0] round;
        logic       update;
        logic       out_adv;
        logic       clear;
    } cmd_t;

    typedef struct packed {
        logic [5:0] fill;
        logic       out_last;
    } status_t;

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] v;
        begin
            case (i)
                3'd0: v = 32'h6A09E667;
                3'd1: v = 32'hBB67AE85;
                3'd2: v = 32'h3C6EF372;
                3'd3: v = 32'hA54FF53A;
                3'd4: v = 32'h510E527F;
                3'd5: v = 32'h9B05688C;
                3'd6: v = 32'h1F83D9AB;
                default: v = 32'h5BE0CD19;
            endcase
            return v;
        end
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] v;
        begin
            case (i)
                6'd0:  v = 32'h428A2F98; 6'd1:  v = 32'h71374491;
                6'd2:  v = 32'hB5C0FBCF; 6'd3:  v = 32'hE9B5DBA5;
                6'd4:  v = 32'h3956C25B; 6'd5:  v = 32'h59F111F1;
                6'd6:  v = 32'h923F82A4; 6'd7:  v = 32'hAB1C5ED5;
                6'd8:  v = 32'hD807AA98; 6'd9:  v = 32'h12835B01;
                6'd10: v = 32'h243185BE; 6'd11: v = 32'h550C7DC3;
                6'd12: v = 32'h72BE5D74; 6'd13: v = 32'h80DEB1FE;
                6'd14: v = 32'h9BDC06A7; 6'd15: v = 32'hC19BF174;
                6'd16: v = 32'hE49B69C1; 6'd17: v = 32'hEFBE4786;
                6'd18: v = 32'h0FC19DC6; 6'd19: v = 32'h240CA1CC;
                6'd20: v = 32'h2DE92C6F; 6'd21: v = 32'h4A7484AA;
                6'd22: v = 32'h5CB0A9DC; 6'd23: v = 32'h76F988DA;
                6'd24: v = 32'h983E5152; 6'd25: v = 32'hA831C66D;
                6'd26: v = 32'hB00327C8; 6'd27: v = 32'hBF597FC7;
                6'd28: v = 32'hC6E00BF3; 6'd29: v = 32'hD5A79147;
                6'd30: v = 32'h06CA6351; 6'd31: v = 32'h14292967;
                6'd32: v = 32'h27B70A85; 6'd33: v = 32'h2E1B2138;
                6'd34: v = 32'h4D2C6DFC; 6'd35: v = 32'h53380D13;
                6'd36: v = 32'h650A7354; 6'd37: v = 32'h766A0ABB;
                6'd38: v = 32'h81C2C92E; 6'd39: v = 32'h92722C85;
                6'd40: v = 32'hA2BFE8A1; 6'd41: v = 32'hA81A664B;
                6'd42: v = 32'hC24B8B70; 6'd43: v = 32'hC76C51A3;
                6'd44: v = 32'hD192E819; 6'd45: v = 32'hD6990624;
                6'd46: v = 32'hF40E3585; 6'd47: v = 32'h106AA070;
                6'd48: v = 32'h19A4C116; 6'd49: v = 32'h1E376C08;
                6'd50: v = 32'h2748774C; 6'd51: v = 32'h34B0BCB5;
                6'd52: v = 32'h391C0CB3; 6'd53: v = 32'h4ED8AA4A;
                6'd54: v = 32'h5B9CCA4F; 6'd55: v = 32'h682E6FF3;
                6'd56: v = 32'h748F82EE; 6'd57: v = 32'h78A5636F;
                6'd58: v = 32'h84C87814; 6'd59: v = 32'h8CC70208;
                6'd60: v = 32'h90BEFFFA; 6'd61: v = 32'hA4506CEB;
                6'd62: v = 32'hBEF9A3F7;
                default: v = 32'hC67178F2;
            endcase
            return v;
        end
    endfunction

endpackage

// File: sv/s256h_datapath.sv
// Datapath of the SHA-256 hasher: block buffer, schedule, round logic and hash state.
module s256h_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  s256h_pkg::cmd_t     cmd,
    input  logic [7:0]          data_byte,
    output s256h_pkg::status_t  status,
    output logic [31:0]         digest_word,
    output logic [2:0]          word_index
);

    function automatic logic [31:0] ror(input logic [31:0] v, input int s);
        begin
            return (v >> s) | (v << (32 - s));
        end
    endfunction

    logic [31:0] w_reg    [16];
    logic [31:0] w_next   [16];
    logic [31:0] hash_reg [8];
    logic [31:0] hash_next[8];
    logic [31:0] work_reg [8];
    logic [31:0] work_next[8];
    logic [5:0]  fill_reg, fill_next;
    logic [60:0] count_reg, count_next;
    logic [2:0]  idx_reg, idx_next;

    logic [7:0]  wr_byte;
    logic [63:0] len_shift;
    logic [3:0]  wr_word;
    logic [1:0]  wr_lane;
    logic [31:0] s0, s1, w_new;
    logic [31:0] big0, big1, choose, major, t1, t2;

    always_comb
    begin
        len_shift = {count_reg, 3'b000} << {fill_reg[2:0], 3'b000};
        if (cmd.load_byte)
            wr_byte = data_byte;
        else if (cmd.pad_mark)
            wr_byte = s256h_pkg::PAD_MARK;
        else if (cmd.pad_len)
            wr_byte = len_shift[63:56];
        else
            wr_byte = 8'h00;
        wr_word = fill_reg[5:2];
        wr_lane = ~fill_reg[1:0];

        s0 = ror(w_reg[1], 7) ^ ror(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = ror(w_reg[14], 17) ^ ror(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;

        big1   = ror(work_reg[4], 6) ^ ror(work_reg[4], 11) ^ ror(work_reg[4], 25);
        choose = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
        t1     = work_reg[7] + big1 + choose + s256h_pkg::round_k(cmd.round) + w_reg[0];
        big0   = ror(work_reg[0], 2) ^ ror(work_reg[0], 13) ^ ror(work_reg[0], 22);
        major  = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
               ^ (work_reg[1] & work_reg[2]);
        t2     = big0 + major;

        w_next     = w_reg;
        hash_next  = hash_reg;
        work_next  = work_reg;
        fill_next  = fill_reg;
        count_next = count_reg;
        idx_next   = idx_reg;

        if (cmd.load_byte || cmd.pad_mark || cmd.pad_fill || cmd.pad_len)
        begin
            w_next[wr_word][{wr_lane, 3'b000} +: 8] = wr_byte;
            fill_next = fill_reg + 6'd1;
        end
        if (cmd.load_byte)
            count_next = count_reg + 61'd1;

        if (cmd.start_round)
            work_next = hash_reg;

        if (cmd.round_step)
        begin
            for (int i = 0; i < 15; i++)
                w_next[i] = w_reg[i + 1];
            w_next[15]   = w_new;
            work_next[7] = work_reg[6];
            work_next[6] = work_reg[5];
            work_next[5] = work_reg[4];
            work_next[4] = work_reg[3] + t1;
            work_next[3] = work_reg[2];
            work_next[2] = work_reg[1];
            work_next[1] = work_reg[0];
            work_next[0] = t1 + t2;
        end

        if (cmd.update)
        begin
            for (int i = 0; i < 8; i++)
                hash_next[i] = hash_reg[i] + work_reg[i];
        end

        if (cmd.out_adv)
            idx_next = idx_reg + 3'd1;

        if (cmd.clear)
        begin
            for (int i = 0; i < 8; i++)
                hash_next[i] = s256h_pkg::init_h(3'(i));
            fill_next  = '0;
            count_next = '0;
            idx_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= s256h_pkg::init_h(3'(i));
            fill_reg  <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            hash_reg  <= hash_next;
            fill_reg  <= fill_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg    <= w_next;
        work_reg <= work_next;
    end

    assign status.fill     = fill_reg;
    assign status.out_last = (idx_reg == 3'd7);
    assign digest_word     = hash_reg[idx_reg];
    assign word_index      = idx_reg;

endmodule

// File: sv/s256h_ctrl.sv
// Controller of the SHA-256 hasher: sequences loading, padding, rounds and digest output.
`include "assert_macros.svh"
module s256h_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_has_byte,
    input  logic                in_eom,
    output logic                out_valid,
    input  logic                out_ready,
    input  s256h_pkg::status_t  status,
    output s256h_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_UPDATE,
        S_PAD,
        S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] round_reg, round_next;
    logic       eom_pend_reg, eom_pend_next;
    logic       pad_first_reg, pad_first_next;
    logic       pad_wrap_reg, pad_wrap_next;
    logic       padding_reg, padding_next;

    always_comb
    begin
        state_next     = state_reg;
        round_next     = round_reg;
        eom_pend_next  = eom_pend_reg;
        pad_first_next = pad_first_reg;
        pad_wrap_next  = pad_wrap_reg;
        padding_next   = padding_reg;
        cmd            = '0;
        cmd.round      = round_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_byte = in_has_byte;
                    if (in_has_byte && status.fill == s256h_pkg::LAST_FILL)
                    begin
                        cmd.start_round = 1'b1;
                        round_next      = '0;
                        eom_pend_next   = in_eom;
                        state_next      = S_ROUND;
                    end
                    else if (in_eom)
                    begin
                        pad_first_next = 1'b1;
                        padding_next   = 1'b1;
                        state_next     = S_PAD;
                    end
                end
            end
            S_ROUND:
            begin
                cmd.round_step = 1'b1;
                round_next     = round_reg + 6'd1;
                if (round_reg == s256h_pkg::LAST_ROUND)
                    state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                if (padding_reg)
                begin
                    if (pad_wrap_reg)
                    begin
                        pad_wrap_next = 1'b0;
                        state_next    = S_PAD;
                    end
                    else
                        state_next = S_OUT;
                end
                else if (eom_pend_reg)
                begin
                    eom_pend_next  = 1'b0;
                    pad_first_next = 1'b1;
                    padding_next   = 1'b1;
                    state_next     = S_PAD;
                end
                else
                    state_next = S_IDLE;
            end
            S_PAD:
            begin
                if (pad_first_reg)
                begin
                    cmd.pad_mark   = 1'b1;
                    pad_first_next = 1'b0;
                    // A mark that lands in the last eight bytes pushes the length out.
                    pad_wrap_next  = (status.fill >= s256h_pkg::LEN_OFFSET);
                end
                else if (status.fill >= s256h_pkg::LEN_OFFSET && !pad_wrap_reg)
                    cmd.pad_len = 1'b1;
                else
                    cmd.pad_fill = 1'b1;
                if (status.fill == s256h_pkg::LAST_FILL)
                begin
                    cmd.start_round = 1'b1;
                    round_next      = '0;
                    state_next      = S_ROUND;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    cmd.out_adv = 1'b1;
                    if (status.out_last)
                    begin
                        cmd.clear     = 1'b1;
                        padding_next  = 1'b0;
                        pad_wrap_next = 1'b0;
                        state_next    = S_IDLE;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            round_reg     <= '0;
            eom_pend_reg  <= 1'b0;
            pad_first_reg <= 1'b0;
            pad_wrap_reg  <= 1'b0;
            padding_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            eom_pend_reg  <= eom_pend_next;
            pad_first_reg <= pad_first_next;
            pad_wrap_reg  <= pad_wrap_next;
            padding_reg   <= padding_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    `ASSERT_IMPL(a_no_overlap, clk, rst_n, out_valid, !in_ready)
    `ASSERT_NEXT(a_last_frees, clk, rst_n, out_valid && out_ready && status.out_last, in_ready)
    `ASSERT_NEXT(a_rounds_end, clk, rst_n,
        state_reg == S_ROUND && round_reg == s256h_pkg::LAST_ROUND, state_reg == S_UPDATE)

endmodule

// File: sv/sha256_stream_hasher.sv
// SHA-256 stream hasher: takes at most one message byte per beat and returns the
// eight digest words after the beat marked tlast. Each full 64-byte block
// then occupies the single round unit for 64 rounds and one state update,
// during which s_tready is low. Padding writes one byte per cycle into the
// block buffer, and a second block is compressed when the length spills
// over, before the eight words leave, one per accepted beat. No new beat is
// taken while padding, compressing a block or outputting the digest words.
module sha256_stream_hasher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] has_byte
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
    output logic        m_tlast    // last_word
);

    s256h_pkg::cmd_t    cmd;
    s256h_pkg::status_t status;
    logic [31:0]        digest_word;
    logic [2:0]         word_index;

    s256h_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_has_byte (s_tuser),
        .in_eom      (s_tlast),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .status      (status),
        .cmd         (cmd)
    );

    s256h_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (s_tdata),
        .status      (status),
        .digest_word (digest_word),
        .word_index  (word_index)
    );

    assign m_tdata = {5'b00000, word_index, digest_word};
    assign m_tlast = status.out_last;

endmodule

// File: tb/tb_sha256_stream_hasher.sv
// Self-checking testbench for the SHA-256 stream hasher with a built-in digest predictor.
module tb_sha256_stream_hasher;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        s_tuser;   // [0] has_byte
    logic        s_tlast;   // end_of_message
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [31:0] digest_word, [34:32] word_index, rest zero
    logic        m_tlast;   // last_word

    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    digest_beat_t pending_words[$];

    logic [31:0] h_state [8];
    logic [7:0]  blk [64];
    int unsigned fill;
    logic [60:0] byte_count;

    int mismatches = 0;
    int words_seen = 0;
    int messages_sent;
    int beats_sent;
    int idle_cycles = 0;

    sha256_stream_hasher uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
        return (v >> s) | (v << (32 - s));
    endfunction

    // Round constants: first 32 bits of the fractional cube roots of the first 64 primes.
    function automatic logic [31:0] kconst(input int i);
        logic [31:0] k [64];
        k = '{32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B,
              32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01,
              32'h243185BE, 32'h550C7DC3, 32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7,
              32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
              32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA, 32'h983E5152,
              32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
              32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC,
              32'h53380D13, 32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
              32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3, 32'hD192E819,
              32'hD6990624, 32'hF40E3585, 32'h106AA070, 32'h19A4C116, 32'h1E376C08,
              32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F,
              32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
              32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};
        return k[i];
    endfunction

    task automatic clear_hash();
        h_state = '{32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
                    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};
        fill = 0;
        byte_count = '0;
    endtask

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        a = h_state[0]; b = h_state[1]; c = h_state[2]; d = h_state[3];
        e = h_state[4]; f = h_state[5]; g = h_state[6]; h = h_state[7];
        for (int i = 0; i < 64; i++)
        begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + kconst(i) + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        h_state[0] += a; h_state[1] += b; h_state[2] += c; h_state[3] += d;
        h_state[4] += e; h_state[5] += f; h_state[6] += g; h_state[7] += h;
    endtask

    // Advances the digest predictor by one beat and queues any digest words it yields.
    task automatic predict_digest(input logic [7:0] data, input logic has, input logic eom);
        logic [63:0] bits;
        digest_beat_t beat;
        if (has)
        begin
            blk[fill] = data;
            fill++;
            byte_count++;
            if (fill == 64)
            begin
                compress();
                fill = 0;
            end
        end
        if (eom)
        begin
            blk[fill] = 8'h80;
            fill++;
            if (fill > 56)
            begin
                while (fill < 64)
                begin
                    blk[fill] = 8'h00;
                    fill++;
                end
                compress();
                fill = 0;
            end
            while (fill < 56)
            begin
                blk[fill] = 8'h00;
                fill++;
            end
            bits = {byte_count, 3'b000};
            for (int i = 0; i < 8; i++)
                blk[56+i] = bits[63-8*i -: 8];
            compress();
            for (int i = 0; i < 8; i++)
            begin
                beat.word = h_state[i];
                beat.index = 3'(i);
                beat.last = (i == 7);
                pending_words = {pending_words, beat};
            end
            clear_hash();
        end
    endtask

    // The valid line stays high into a following beat that comes without a gap.
    task automatic send_beat(input logic [7:0] data, input logic has, input logic eom,
                             input bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : ((($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17)));
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= has;
        s_tlast  <= eom;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_digest(data, has, eom);
        beats_sent++;
        if (eom)
            messages_sent++;
    endtask

    task automatic send_message(input int len, input bit no_gap = 0);
        for (int i = 0; i < len; i++)
            send_beat(8'($urandom), 1'b1, 1'b0, no_gap);
        send_beat(8'($urandom), 1'b0, 1'b1, no_gap);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_message();
        send_beat(8'hFF, 1'b0, 1'b1);
        send_beat(8'hAA, 1'b0, 1'b0);
        send_beat(8'h55, 1'b0, 1'b1);
    endtask

    task automatic test_byte_extremes();
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b0, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b1);
        send_beat(8'h00, 1'b1, 1'b1);
        send_beat(8'hA5, 1'b1, 1'b0);
        send_beat(8'h5A, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
    endtask

    // Lengths around the padding boundary and the block boundary, back to back.
    task automatic test_block_boundaries();
        int lens [3] = '{55, 56, 64};
        foreach (lens[i])
        begin
            for (int j = 0; j < lens[i] - 1; j++)
                send_beat(8'($urandom), 1'b1, 1'b0, 1);
            send_beat(8'($urandom), 1'b1, 1'b1, 1);
        end
    endtask

    // Waits for every digest word before the next message.
    task automatic test_pause_for_results();
        send_message(3);
        wait_drained();
        send_message(8);
        wait_drained();
    endtask

    task automatic test_random_messages();
        int len;
        int target;
        target = beats_sent + 80;
        while (beats_sent < target)
        begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 12);
            if (len > target - beats_sent)
                len = target - beats_sent;
            for (int i = 0; i < len; i++)
            begin
                // Some noise beats without a byte are mixed into the message.
                if ($urandom_range(0, 7) == 0)
                    send_beat(8'($urandom), 1'b0, 1'b0);
                send_beat(8'($urandom), 1'b1, 1'b0);
            end
            send_beat(8'($urandom), 1'($urandom), 1'b1);
        end
    endtask

    // Receiver: draws a wait before each digest word, often none.
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        digest_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            words_seen++;
            if (pending_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected digest word %h", m_tdata);
            end
            else
            begin
                want = pending_words.pop_front();
                if (m_tdata[31:0] !== want.word || m_tdata[34:32] !== want.index
                    || m_tlast !== want.last || m_tdata[39:35] !== 5'd0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("digest mismatch: expected word %h index %0d last %b, got %h %0d %b",
                                 want.word, want.index, want.last,
                                 m_tdata[31:0], m_tdata[34:32], m_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("sha256_stream_hasher test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        messages_sent = 0;
        beats_sent = 0;
        for (int i = 0; i < 64; i++)
            blk[i] = 8'h00;
        clear_hash();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_message();
        test_byte_extremes();
        test_block_boundaries();
        test_pause_for_results();
        test_random_messages();
        wait_drained();
        repeat (300) @(posedge clk);
        $display("Sent %0d beats forming %0d messages, checked %0d digest words.",
                 beats_sent, messages_sent, words_seen);
        $display("Covered empty messages, padding across a block and random stalls.");
        if (mismatches == 0 && pending_words.size() == 0)
            $display("sha256_stream_hasher test passed");
        else
            $display("sha256_stream_hasher test failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/s256h_pkg.sv
sv/s256h_datapath.sv
sv/s256h_ctrl.sv
sv/sha256_stream_hasher.sv
tb/tb_sha256_stream_hasher.sv
